[sv/tvbs_pkg.sv]
// Package: format codes, byte item type and shared constants of the serializer.
package tvbs_pkg;

  typedef enum logic [2:0] {
    MODE_FIX8   = 3'd0,
    MODE_FIX16  = 3'd1,
    MODE_FIX32  = 3'd2,
    MODE_FIX64  = 3'd3,
    MODE_VAR32  = 3'd4,
    MODE_ZZ32   = 3'd5,
    MODE_VAR64  = 3'd6,
    MODE_ZZ64   = 3'd7
  } mode_t;

  localparam logic [7:0] VARINT_MORE = 8'h80;
  localparam logic [6:0] VARINT_MASK = 7'h7F;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } byte_item_t;

endpackage

[sv/tvbs_shifter.sv]
// Shift register that splits one loaded value into its serialized bytes.
module tvbs_shifter
  import tvbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  mode_t       load_mode,
  input  logic [63:0] load_value,
  input  logic        msb_first,
  input  logic        advance,
  output byte_item_t  item
);

  logic        busy;
  logic        varint;
  logic        msb;
  logic [3:0]  count;
  logic [63:0] sreg;

  logic [63:0] sreg_next;
  logic [3:0]  count_next;
  logic        varint_next;
  logic        more;
  logic [31:0] w32;

  assign w32 = load_value[31:0];

  always_comb begin
    sreg_next   = load_value;
    count_next  = 4'd1;
    varint_next = 1'b0;
    unique case (load_mode)
      MODE_FIX8: begin
        sreg_next  = msb_first ? {load_value[7:0], 56'd0} : {56'd0, load_value[7:0]};
        count_next = 4'd1;
      end
      MODE_FIX16: begin
        sreg_next  = msb_first ? {load_value[15:0], 48'd0} : {48'd0, load_value[15:0]};
        count_next = 4'd2;
      end
      MODE_FIX32: begin
        sreg_next  = msb_first ? {w32, 32'd0} : {32'd0, w32};
        count_next = 4'd4;
      end
      MODE_FIX64: begin
        sreg_next  = load_value;
        count_next = 4'd8;
      end
      MODE_VAR32: begin
        sreg_next   = {32'd0, w32};
        varint_next = 1'b1;
      end
      MODE_ZZ32: begin
        sreg_next   = {32'd0, {w32[30:0], 1'b0} ^ {32{w32[31]}}};
        varint_next = 1'b1;
      end
      MODE_VAR64: begin
        sreg_next   = load_value;
        varint_next = 1'b1;
      end
      MODE_ZZ64: begin
        sreg_next   = {load_value[62:0], 1'b0} ^ {64{load_value[63]}};
        varint_next = 1'b1;
      end
      default: begin
        sreg_next = load_value;
      end
    endcase
  end

  assign more = |sreg[63:7];

  always_comb begin
    item.valid = busy;
    if (varint) begin
      item.data = more ? ({1'b0, sreg[6:0] & VARINT_MASK} | VARINT_MORE) : sreg[7:0];
      item.last = !more;
    end else begin
      item.data = msb ? sreg[63:56] : sreg[7:0];
      item.last = (count == 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (advance && busy) begin
      busy <= !item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sreg   <= sreg_next;
      count  <= count_next;
      varint <= varint_next;
      msb    <= msb_first;
    end else if (advance && busy) begin
      count <= count - 4'd1;
      if (varint) begin
        sreg <= {7'd0, sreg[63:7]};
      end else if (msb) begin
        sreg <= {sreg[55:0], 8'd0};
      end else begin
        sreg <= {8'd0, sreg[63:8]};
      end
    end
  end

endmodule

[sv/typed_value_byte_serializer.sv]
// Top level: typed value to byte stream serializer with byte order register.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    mode, value
//  out       output     out_valid / out_ready  out_byte, last
//  cfg       input      cfg_valid / cfg_ready  cfg_data (big_endian)
//
// One byte leaves the shift register per cycle while out_ready does not stall
// it; an item is loaded first and then yields its byte count (1 to 10).
// The next item is taken once the shift register has handed its last byte to
// the output register, even while that byte still waits on out_ready.
// Reset (rst, synchronous) empties both stages and sets big_endian to 1.
// A stall on out_ready holds the output register and the shift register.
module typed_value_byte_serializer
  import tvbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic       big_endian;
  logic       load;
  logic       advance;
  byte_item_t sh_item;

  assign cfg_ready = 1'b1;
  assign in_ready  = !sh_item.valid;
  assign load      = in_valid && in_ready;
  assign advance   = sh_item.valid && (!out_valid || out_ready);

  tvbs_shifter u_shifter (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_mode  (mode_t'(mode)),
    .load_value (value),
    .msb_first  (big_endian),
    .advance    (advance),
    .item       (sh_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      big_endian <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= sh_item.data;
      last     <= sh_item.last;
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> sh_item.valid)
    else $error("loaded item produced no byte");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (advance && sh_item.last) |=> in_ready)
    else $error("shifter still busy after final byte");

  a_byte_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced byte missing from output register");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && in_ready))
    else $error("stages not empty after reset");

endmodule
